[hw/rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    // result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_ENTRY    = 2'd3;

    // legal priority range, out-of-range values are clamped to it
    localparam logic [2:0] PRIO_MIN = 3'd1;
    localparam logic [2:0] PRIO_MAX = 3'd5;

    // command queue between front and back, depth must be a power of two
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_FILL_W     = $clog2(CMD_FIFO_DEPTH + 1);

    // request beat
    typedef struct packed {
        logic       req_type;
        logic [2:0] priority_req;
        logic [7:0] tag;
    } req_t;

    // response beat
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] out_priority;
        logic [7:0] out_tag;
        logic       last;
    } rsp_t;

    // classified command, tag travels beside it at the stored width
    typedef struct packed {
        logic       is_list;
        logic [2:0] prio;
    } cmd_t;

endpackage

[hw/rtl/spq_front.sv]
`timescale 1ns / 1ps

module spq_front
    import spq_pkg::*;
#(
    parameter int TAG_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req,
    output logic                cmd_valid,
    output cmd_t                cmd,
    output logic [TAG_BITS-1:0] cmd_tag,
    input  logic                cmd_pop
);

    cmd_t                cmd_mem [CMD_FIFO_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [CMD_FIFO_DEPTH];

    logic [CMD_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMD_FILL_W-1:0] fill_reg, fill_next;

    logic                push;
    cmd_t                cmd_in;
    logic [TAG_BITS+7:0] tag_wide;
    logic [TAG_BITS-1:0] tag_in;

    // classify and clamp the incoming beat
    always_comb
    begin
        cmd_in.is_list = req.req_type;
        if (req.priority_req < PRIO_MIN)
        begin
            cmd_in.prio = PRIO_MIN;
        end
        else if (req.priority_req > PRIO_MAX)
        begin
            cmd_in.prio = PRIO_MAX;
        end
        else
        begin
            cmd_in.prio = req.priority_req;
        end
    end

    // keep the low TAG_BITS bits of the tag, zero extended when wider
    assign tag_wide = {{TAG_BITS{1'b0}}, req.tag};
    assign tag_in   = tag_wide[TAG_BITS-1:0];

    // queue control
    assign req_stall = (fill_reg == CMD_FILL_W'(CMD_FIFO_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = cmd_mem[rd_ptr_reg];
    assign cmd_tag   = tag_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg] <= cmd_in;
            tag_mem[wr_ptr_reg] <= tag_in;
        end
    end

endmodule

[hw/rtl/spq_back.sv]
`timescale 1ns / 1ps

module spq_back
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    input  logic [TAG_BITS-1:0] cmd_tag,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // sorted row of cells, cell 0 is the most urgent
    logic [2:0]          prio_reg  [QUEUE_DEPTH];
    logic [2:0]          prio_next [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_reg   [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_next  [QUEUE_DEPTH];

    // neighbor taps of each cell
    logic [2:0]          prio_up [QUEUE_DEPTH];
    logic [2:0]          prio_dn [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_up  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] tag_dn  [QUEUE_DEPTH];

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_m1;

    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [TAG_BITS+7:0] head_tag_wide;

    logic [QUEUE_DEPTH-1:0] at;
    logic [QUEUE_DEPTH-1:0] at_prev;

    logic out_load;
    logic full;
    logic empty;
    logic list_last;
    logic do_ins;
    logic do_list;

    // step control
    assign out_load  = !rsp_valid_reg || !rsp_stall;
    assign full      = (count_reg == CW'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign cnt_m1    = count_reg - 1'b1;
    assign list_last = (idx_reg == cnt_m1);
    assign do_ins    = cmd_valid && out_load && !cmd.is_list && !full;
    assign do_list   = cmd_valid && out_load && cmd.is_list && !empty;
    assign cmd_pop   = cmd_valid && out_load && (!cmd.is_list || empty || list_last);

    // neighbor wiring, the end cells see a value that is never selected
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_tap
        if (g < QUEUE_DEPTH - 1)
        begin : g_up
            assign prio_up[g] = prio_reg[g+1];
            assign tag_up[g]  = tag_reg[g+1];
        end
        else
        begin : g_up_end
            assign prio_up[g] = prio_reg[g];
            assign tag_up[g]  = tag_reg[g];
        end
        if (g > 0)
        begin : g_dn
            assign prio_dn[g] = prio_reg[g-1];
            assign tag_dn[g]  = tag_reg[g-1];
        end
        else
        begin : g_dn_end
            assign prio_dn[g] = prio_reg[g];
            assign tag_dn[g]  = tag_reg[g];
        end
    end

    // insert point: first stored cell of larger priority, or the first free cell
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            at[i] = ((CW'(i) < count_reg) && (prio_reg[i] > cmd.prio)) ||
                    (CW'(i) == count_reg);
        end
    end

    assign at_prev = {at[QUEUE_DEPTH-2:0], 1'b0};

    // cell update: shift on insert, rotate the stored part on list
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            tag_next[i]  = tag_reg[i];
            if (do_ins)
            begin
                if (at_prev[i])
                begin
                    prio_next[i] = prio_dn[i];
                    tag_next[i]  = tag_dn[i];
                end
                else if (at[i])
                begin
                    prio_next[i] = cmd.prio;
                    tag_next[i]  = cmd_tag;
                end
            end
            else if (do_list)
            begin
                if (CW'(i) == cnt_m1)
                begin
                    prio_next[i] = prio_reg[0];
                    tag_next[i]  = tag_reg[0];
                end
                else if (CW'(i) < cnt_m1)
                begin
                    prio_next[i] = prio_up[i];
                    tag_next[i]  = tag_up[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            prio_reg[i] <= prio_next[i];
            tag_reg[i]  <= tag_next[i];
        end
    end

    // fill count and list position
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        if (do_list)
        begin
            idx_next = list_last ? '0 : idx_reg + 1'b1;
        end
    end

    // response beat, head cell holds the entry being listed
    assign head_tag_wide = {8'b0, tag_reg[0]};

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (out_load)
        begin
            rsp_valid_next        = cmd_valid;
            rsp_next.out_priority = 3'd0;
            rsp_next.out_tag      = 8'd0;
            rsp_next.last         = 1'b1;
            if (cmd.is_list)
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.status       = ST_ENTRY;
                    rsp_next.out_priority = prio_reg[0];
                    rsp_next.out_tag      = head_tag_wide[7:0];
                    rsp_next.last         = list_last;
                end
            end
            else
            begin
                rsp_next.status = full ? ST_FULL : ST_INSERTED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // fill count stays within the row
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // list position points at a stored entry
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> (idx_reg < count_reg))
        else $error("list position past stored entries");

    // an accepted insert grows the store by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the store");

    // a listed entry never comes from an empty store
    a_entry_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_ENTRY)) |-> (count_reg != '0))
        else $error("listed entry from empty store");
`endif

endmodule

[hw/rtl/stable_priority_queue_unit.sv]
`timescale 1ns / 1ps

// Stable priority queue of alerts. Insert requests store a clamped priority
// (1 most urgent .. 5 least) and a tag behind every entry of equal or more
// urgent priority; list requests return every stored entry in order, one
// response beat per entry with last on the final one, without removing any.
// A front stage classifies requests into a two-entry command queue; the back
// holds the entries in a compare-and-shift row of QUEUE_DEPTH cells. An
// insert, a rejected insert or an empty list gives one beat; a list of n
// entries gives n beats, one beat per cycle unless stalled, as the row
// rotates its stored part past the head cell and ends in its original
// order. Responses sit in an output register that keeps the back running
// while the consumer takes the previous beat. No clearing pass after reset.

module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic                cmd_valid;
    cmd_t                cmd;
    logic [TAG_BITS-1:0] cmd_tag;
    logic                cmd_pop;

    // request classification and command queue
    spq_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_tag   (cmd_tag),
        .cmd_pop   (cmd_pop)
    );

    // sorted row, list sequencing and response register
    spq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_tag   (cmd_tag),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[sim/stable_priority_queue_unit_tb.sv]
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_REQS = 447;
    localparam int QUIET_TAIL  = 50;
    localparam int HANG_LIMIT  = 2000;
    localparam int SETTLE      = 20;

    // one pending request, optionally held back until all answers are in
    typedef struct {
        req_t beat;
        bit   wait_drain;
    } alert_req_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    stable_priority_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // shadow copy of the sorted alert store
    logic [2:0] shadow_prio [DEPTH];
    logic [7:0] shadow_tag  [DEPTH];
    int         shadow_fill = 0;

    alert_req_t pending_alerts [$];
    rsp_t       owed_rsps      [$];

    int  total_reqs    = 0;
    int  accepted_reqs = 0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  send_gap      = 0;
    int  stall_gap     = 0;
    bit  req_taken     = 1'b0;
    int  n_stored      = 0;
    int  n_rejected    = 0;
    int  n_lists       = 0;
    int  n_empty_lists = 0;
    int  n_entries     = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic void queue_alert(input logic kind, input logic [2:0] prio,
                                        input logic [7:0] id, input bit drain);
        alert_req_t a;
        a.beat.req_type     = kind;
        a.beat.priority_req = prio;
        a.beat.tag          = id;
        a.wait_drain        = drain;
        pending_alerts.push_back(a);
        total_reqs++;
    endfunction

    // idling comes in stretches, and stops for the tail of the run
    function automatic bit idling_allowed();
        return (pending_alerts.size() > QUIET_TAIL) && (((accepted_reqs / 40) % 4) != 3);
    endfunction

    // sorted insert or ordered listing, pushes the answers it owes
    function automatic void answer_request(input req_t beat);
        logic [2:0] prio;
        int         slot;
        int         i;
        rsp_t       r;
        r      = '0;
        r.last = 1'b1;
        if (beat.req_type == 1'b0) begin
            if (shadow_fill >= DEPTH) begin
                r.status = ST_FULL;
                n_rejected++;
            end else begin
                prio = beat.priority_req;
                if (prio < PRIO_MIN)
                    prio = PRIO_MIN;
                if (prio > PRIO_MAX)
                    prio = PRIO_MAX;
                // new alert goes behind every entry of equal or lower number
                slot = shadow_fill;
                for (i = shadow_fill - 1; i >= 0; i--)
                    if (shadow_prio[i] > prio)
                        slot = i;
                for (i = shadow_fill; i > slot; i--) begin
                    shadow_prio[i] = shadow_prio[i - 1];
                    shadow_tag[i]  = shadow_tag[i - 1];
                end
                shadow_prio[slot] = prio;
                shadow_tag[slot]  = beat.tag;
                shadow_fill++;
                r.status = ST_INSERTED;
                n_stored++;
            end
            owed_rsps.push_back(r);
        end else begin
            n_lists++;
            if (shadow_fill == 0) begin
                r.status = ST_EMPTY;
                owed_rsps.push_back(r);
                n_empty_lists++;
            end else begin
                for (i = 0; i < shadow_fill; i++) begin
                    r.status       = ST_ENTRY;
                    r.out_priority = shadow_prio[i];
                    r.out_tag      = shadow_tag[i];
                    r.last         = (i == shadow_fill - 1);
                    owed_rsps.push_back(r);
                end
            end
        end
    endfunction

    function automatic void field_check(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // request driver, changes on the falling edge
    always @(negedge clk) begin
        if (rst_n && !(req_valid && !req_taken)) begin
            if (send_gap > 0) begin
                req_valid <= 1'b0;
                send_gap  <= send_gap - 1;
            end else if (pending_alerts.size() == 0 ||
                         (pending_alerts[0].wait_drain && owed_rsps.size() != 0)) begin
                req_valid <= 1'b0;
            end else begin
                req       <= pending_alerts[0].beat;
                req_valid <= 1'b1;
                pending_alerts.pop_front();
                if (idling_allowed() && $urandom_range(0, 4) == 0)
                    send_gap <= $urandom_range(1, 11);
            end
        end
    end

    // response stall bursts
    always @(negedge clk) begin
        if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
        end else if (idling_allowed() && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            stall_gap <= $urandom_range(0, 10);
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // monitor: check response beats, predict on accepted request beats
    always @(posedge clk) begin
        rsp_t want;
        if (rsp_valid && !rsp_stall) begin
            if (owed_rsps.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual %h", $time, rsp);
                mismatches++;
            end else begin
                want = owed_rsps.pop_front();
                field_check("status", int'(want.status), int'(rsp.status));
                field_check("out_priority", int'(want.out_priority), int'(rsp.out_priority));
                field_check("out_tag", int'(want.out_tag), int'(rsp.out_tag));
                field_check("last", int'(want.last), int'(rsp.last));
                if (want.status == ST_ENTRY)
                    n_entries++;
            end
        end
        req_taken <= req_valid && !req_stall;
        if (req_valid && !req_stall) begin
            answer_request(req);
            accepted_reqs++;
        end
        // watchdog on cycles with no beat on either side
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: %0d cycles without a beat at %0t ns", quiet_cycles, $time);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int k;

        // directed: empty list, clamped and equal priorities, ordering
        queue_alert(1'b1, 3'd7, 8'hFF, 1'b0);
        queue_alert(1'b0, 3'd0, 8'h00, 1'b0);
        queue_alert(1'b0, 3'd7, 8'hFF, 1'b0);
        queue_alert(1'b0, 3'd3, 8'hA5, 1'b0);
        queue_alert(1'b0, 3'd3, 8'h5A, 1'b0);
        queue_alert(1'b0, 3'd1, 8'h11, 1'b0);
        queue_alert(1'b0, 3'd6, 8'h66, 1'b0);
        queue_alert(1'b0, 3'd5, 8'h55, 1'b0);
        queue_alert(1'b0, 3'd2, 8'h22, 1'b0);
        queue_alert(1'b0, 3'd4, 8'h44, 1'b0);
        queue_alert(1'b1, 3'd0, 8'h00, 1'b0);
        queue_alert(1'b0, 3'd3, 8'h33, 1'b0);
        queue_alert(1'b1, 3'd5, 8'hC3, 1'b0);

        // random: inserts fill the store, then mostly rejects and full lists
        for (k = 0; k < RANDOM_REQS; k++)
            queue_alert(($urandom_range(0, 99) < 35), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), (k % 100) == 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || owed_rsps.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        if (owed_rsps.size() != 0)
            mismatches++;

        $display("%0d requests: %0d alerts stored, %0d inserts rejected as full, %0d lists",
                 total_reqs, n_stored, n_rejected, n_lists);
        $display("%0d lists hit an empty store, %0d listed entries checked in order",
                 n_empty_lists, n_entries);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
hw/rtl/spq_pkg.sv
hw/rtl/spq_front.sv
hw/rtl/spq_back.sv
hw/rtl/stable_priority_queue_unit.sv
sim/stable_priority_queue_unit_tb.sv
